/* rtl/rcaf_pkg.sv */
// Shared types, codes and helpers for the remainder and compare ALU.
`default_nettype none
package rcaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 6;

  localparam logic [DataW-1:0] SIGN_8  = 32'h0000_0080;
  localparam logic [DataW-1:0] SIGN_16 = 32'h0000_8000;
  localparam logic [DataW-1:0] SIGN_32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_UREM = 2'd0,
    MODE_SREM = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    WID_8    = 2'd0,
    WID_16   = 2'd1,
    WID_32   = 2'd2,
    WID_NONE = 2'd3
  } wid_t;

  typedef enum logic [1:0] {
    EXT_NONE  = 2'd0,
    EXT_8     = 2'd1,
    EXT_16    = 2'd2,
    EXT_SPARE = 2'd3
  } ext_t;

  // Request to the shared subtract unit.
  typedef struct packed {
    logic start;
    logic cmp;
    wid_t wsel;
  } unit_req_t;

  // Status back from the shared subtract unit.
  typedef struct packed {
    logic done;
    logic borrow;
  } unit_rsp_t;

  function automatic logic [DataW-1:0] sign_of(input wid_t w);
    logic [DataW-1:0] s;
    case (w)
      WID_8:   s = SIGN_8;
      WID_16:  s = SIGN_16;
      default: s = SIGN_32;
    endcase
    return s;
  endfunction

  function automatic logic [DataW-1:0] mask_of(input wid_t w);
    logic [DataW-1:0] m;
    case (w)
      WID_8:   m = (SIGN_8 << 1) - 32'd1;
      WID_16:  m = (SIGN_16 << 1) - 32'd1;
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/rcaf_sub_unit.sv */
// Shared subtractor: one-shot compare or restoring remainder, one bit per cycle.
`default_nettype none
module rcaf_sub_unit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rcaf_pkg::unit_req_t      req,
  input  wire logic [rcaf_pkg::DataW-1:0] opa,
  input  wire logic [rcaf_pkg::DataW-1:0] opb,
  output rcaf_pkg::unit_rsp_t           rsp,
  output logic [rcaf_pkg::DataW-1:0]    result
);
  import rcaf_pkg::*;

  logic             busy;
  logic             done;
  logic             borrow;
  logic [CntW-1:0]  cnt;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] dq;
  logic [DataW-1:0] dvs;

  logic [DataW:0]   rs;
  logic [DataW:0]   sub_a;
  logic [DataW:0]   sub_b;
  logic [DataW+1:0] diff;
  logic [DataW-1:0] rem_next;
  logic [DataW-1:0] dq_load;
  logic [CntW-1:0]  steps;

  // Partial remainder shifted left with the next dividend bit.
  assign rs    = {rem, dq[DataW-1]};
  assign sub_a = busy ? rs : {1'b0, opa};
  assign sub_b = busy ? {1'b0, dvs} : {1'b0, opb};
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};

  // Restore when the trial subtract borrows.
  assign rem_next = diff[DataW+1] ? rs[DataW-1:0] : diff[DataW-1:0];

  always_comb begin
    case (req.wsel)
      WID_8: begin
        dq_load = opa << 24;
        steps   = CntW'(8);
      end
      WID_16: begin
        dq_load = opa << 16;
        steps   = CntW'(16);
      end
      default: begin
        dq_load = opa;
        steps   = CntW'(DataW);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (busy && (cnt == CntW'(1))) || (!busy && req.start && req.cmp);
      if (busy) begin
        rem <= rem_next;
        dq  <= dq << 1;
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy   <= 1'b0;
          result <= rem_next;
        end
      end else if (req.start) begin
        if (req.cmp) begin
          result <= diff[DataW-1:0];
          borrow <= diff[DataW+1];
        end else begin
          rem    <= '0;
          dq     <= dq_load;
          dvs    <= opb;
          cnt    <= steps;
          borrow <= 1'b0;
          busy   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.borrow = borrow;

endmodule
`default_nettype wire

/* rtl/remainder_compare_alu_with_flags.sv */
// The block takes one item at a time: it accepts no new item until the result of the last
// one is written to the output register, and so it holds off while the output stalls. A
// remainder runs the restoring loop in the shared subtract unit, one quotient bit per cycle;
// a compare is a single subtract in that unit, and a zero divisor or an ignored code skips
// the unit and goes straight to the finishing step.
// Reset (synchronous, active high) clears the status flags, the sequencer and the output valid.
`default_nettype none
module remainder_compare_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: first_operand [31:0], second_operand [63:32]
  input  wire logic [63:0] s_tdata,
  // s_tuser: mode [1:0], op_width [3:2], second_extend [5:4]
  input  wire logic [5:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: result_value [31:0]
  output logic [31:0]      m_tdata,
  // m_tuser: write_back [0], divide_by_zero [1], zero_flag [2], negative_flag [3],
  //          odd_flag [4], borrow_flag [5], overflow_flag [6]
  output logic [6:0]       m_tuser
);
  import rcaf_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_LOAD = 5'b00100,
    S_RUN  = 5'b01000,
    S_FIX  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Latched item.
  mode_t            mode;
  wid_t             wsel;
  ext_t             ext;
  logic [DataW-1:0] a_raw;
  logic [DataW-1:0] b_raw;

  // Prepared operands and the plan for the finishing step.
  logic [DataW-1:0] opa;
  logic [DataW-1:0] opb;
  logic             a_sign;
  logic             b_sign;
  logic             neg_fix;
  logic             wb;
  logic             dz;
  logic             upd_basic;
  logic             upd_cmp;
  logic             is_cmp;
  logic [DataW-1:0] res;
  logic             brw;

  // Status flags: bit 0 zero, 1 negative, 2 odd, 3 borrow, 4 overflow.
  logic [4:0]       status_flags;
  logic [4:0]       status_flags_next;

  unit_req_t        req;
  unit_rsp_t        rsp;
  logic [DataW-1:0] unit_result;

  // Combinational view of the prepare step.
  logic [DataW-1:0] sign_m;
  logic [DataW-1:0] mask_m;
  logic [DataW-1:0] b_ext;
  logic [DataW-1:0] a_m;
  logic [DataW-1:0] b_m;
  logic             an;
  logic             bn;
  logic             bad_code;

  // Combinational view of the finishing step.
  logic [DataW-1:0] res_fix;
  logic             res_sign;
  logic             ovf;
  logic             out_free;

  rcaf_sub_unit u_sub (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (rsp),
    .result (unit_result)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Operand preparation: sign-extend the second operand as the extend code asks, then cut both to the width.
  always_comb begin
    sign_m = sign_of(wsel);
    mask_m = mask_of(wsel);
    case (ext)
      EXT_8:   b_ext = {{24{b_raw[7]}}, b_raw[7:0]};
      EXT_16:  b_ext = {{16{b_raw[15]}}, b_raw[15:0]};
      default: b_ext = b_raw;
    endcase
    a_m      = a_raw & mask_m;
    b_m      = b_ext & mask_m;
    an       = |(a_m & sign_m);
    bn       = |(b_m & sign_m);
    bad_code = (mode == MODE_NONE) || (wsel == WID_NONE);
  end

  // Finishing: the signed remainder takes the sign of the dividend, and flags follow the result.
  always_comb begin
    res_fix  = (neg_fix ? (DataW'(0) - res) : res) & mask_m;
    res_sign = |(res_fix & sign_m);
    ovf      = (a_sign != b_sign) && (b_sign == res_sign);
    status_flags_next = status_flags;
    if (upd_basic) begin
      status_flags_next[0] = (res_fix == '0);
      status_flags_next[1] = res_sign;
      status_flags_next[2] = res_fix[0];
    end
    if (upd_cmp) begin
      status_flags_next[3] = brw;
      status_flags_next[4] = ovf;
    end
  end

  always_comb begin
    req.start  = (state == S_LOAD);
    req.cmp    = is_cmp;
    req.wsel   = wsel;
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_PREP;
      S_PREP: begin
        if (bad_code || ((mode != MODE_CMP) && (b_m == '0))) begin
          state_next = S_FIX;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_RUN;
      S_RUN:  if (rsp.done) state_next = S_FIX;
      S_FIX:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      status_flags <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_FIX) && out_free) begin
        status_flags <= status_flags_next;
        m_tvalid     <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          mode  <= mode_t'(s_tuser[1:0]);
          wsel  <= wid_t'(s_tuser[3:2]);
          ext   <= ext_t'(s_tuser[5:4]);
          a_raw <= s_tdata[31:0];
          b_raw <= s_tdata[63:32];
        end
      end
      S_PREP: begin
        is_cmp    <= (mode == MODE_CMP);
        a_sign    <= an;
        b_sign    <= bn;
        res       <= '0;
        brw       <= 1'b0;
        // A remainder with a zero divisor traps; every other valid item updates the flags.
        wb        <= !bad_code && (mode != MODE_CMP) && (b_m != '0);
        dz        <= !bad_code && (mode != MODE_CMP) && (b_m == '0);
        upd_basic <= !bad_code && ((mode == MODE_CMP) || (b_m != '0));
        upd_cmp   <= !bad_code && (mode == MODE_CMP);
        if (mode == MODE_SREM) begin
          // Magnitudes; the most negative value maps to itself as an unsigned number.
          opa     <= an ? ((DataW'(0) - a_m) & mask_m) : a_m;
          opb     <= bn ? ((DataW'(0) - b_m) & mask_m) : b_m;
          neg_fix <= an;
        end else begin
          opa     <= a_m;
          opb     <= b_m;
          neg_fix <= 1'b0;
        end
      end
      S_RUN: begin
        if (rsp.done) begin
          res <= unit_result;
          brw <= rsp.borrow;
        end
      end
      S_FIX: begin
        if (out_free) begin
          m_tdata <= res_fix;
          m_tuser <= {status_flags_next[4], status_flags_next[3], status_flags_next[2],
                      status_flags_next[1], status_flags_next[0], dz, wb};
        end
      end
      default: begin
      end
    endcase
  end

  // The shared unit reports completion only while the sequencer waits for it.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_RUN))
    else $error("subtract unit finished outside the run state");

  // A trap never writes back, and its result is zero.
  a_trap_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata == 32'd0)))
    else $error("divide-by-zero result carries data or write-back");

  // Once an item is taken, the block holds off the next one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in work");

  // Flags change only when a result is written to the output register.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIX) |=> $stable(status_flags))
    else $error("status flags changed outside the finishing step");

endmodule
`default_nettype wire

/* tb/sv/rcaf_alu_checker.sv */
// Checker for the remainder and compare ALU: predicts each result and compares it.
`timescale 1ns / 100ps
module rcaf_alu_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic [5:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic [6:0]  m_tuser,
  output int               errors,
  output int               pending
);
  import rcaf_pkg::*;

  localparam int FLAG_ZERO = 0;
  localparam int FLAG_NEG  = 1;
  localparam int FLAG_ODD  = 2;
  localparam int FLAG_BRW  = 3;
  localparam int FLAG_OVF  = 4;

  typedef struct packed {
    logic [31:0] value;
    logic        write_back;
    logic        div_zero;
    logic        zero;
    logic        negative;
    logic        odd;
    logic        borrow;
    logic        overflow;
  } alu_result_t;

  logic [4:0]  status_flags = '0;
  alu_result_t alu_results[$];

  function automatic alu_result_t predict_alu_result(input mode_t op, input wid_t wsel,
                                                     input ext_t ext, input logic [31:0] a_raw,
                                                     input logic [31:0] b_raw,
                                                     input logic [4:0] flags_in);
    alu_result_t r;
    logic [31:0] sign, mask, a, b, mag_a, mag_b, rem;
    logic [4:0]  f;
    f = flags_in;
    r = '0;
    if (op != MODE_NONE && wsel != WID_NONE) begin
      case (wsel)
        WID_8:   sign = SIGN_8;
        WID_16:  sign = SIGN_16;
        default: sign = SIGN_32;
      endcase
      mask = (sign << 1) - 32'd1;
      case (ext)
        EXT_8:   b = {{24{b_raw[7]}}, b_raw[7:0]};
        EXT_16:  b = {{16{b_raw[15]}}, b_raw[15:0]};
        default: b = b_raw;
      endcase
      a = a_raw & mask;
      b = b & mask;
      if (op == MODE_CMP) begin
        r.value = (a - b) & mask;
        f[FLAG_BRW] = r.value > a;
        f[FLAG_OVF] = ((a & sign) != (b & sign)) && ((b & sign) == (r.value & sign));
      end else if (b == 32'd0) begin
        r.div_zero = 1'b1;
      end else begin
        if (op == MODE_UREM) begin
          r.value = a % b;
        end else begin
          // Truncating remainder: work on magnitudes, the sign follows the dividend.
          mag_a = ((a & sign) != 0) ? ((32'd0 - a) & mask) : a;
          mag_b = ((b & sign) != 0) ? ((32'd0 - b) & mask) : b;
          rem   = mag_a % mag_b;
          r.value = ((a & sign) != 0) ? ((32'd0 - rem) & mask) : rem;
        end
        r.write_back = 1'b1;
      end
      if (!r.div_zero) begin
        f[FLAG_ZERO] = (r.value == 32'd0);
        f[FLAG_NEG]  = ((r.value & sign) != 0);
        f[FLAG_ODD]  = r.value[0];
      end
    end
    r.zero     = f[FLAG_ZERO];
    r.negative = f[FLAG_NEG];
    r.odd      = f[FLAG_ODD];
    r.borrow   = f[FLAG_BRW];
    r.overflow = f[FLAG_OVF];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    alu_result_t want;
    alu_result_t got;
    if (rst) begin
      status_flags = '0;
      alu_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want = predict_alu_result(mode_t'(s_tuser[1:0]), wid_t'(s_tuser[3:2]),
                                  ext_t'(s_tuser[5:4]), s_tdata[31:0], s_tdata[63:32],
                                  status_flags);
        alu_results.push_back(want);
        status_flags = {want.overflow, want.borrow, want.odd, want.negative, want.zero};
      end
      if (m_tvalid && m_tready) begin
        got.value = m_tdata;
        {got.overflow, got.borrow, got.odd, got.negative, got.zero, got.div_zero,
         got.write_back} = m_tuser;
        if (alu_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h / %b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = alu_results.pop_front();
          check_field("result_value", want.value, got.value);
          check_field("write_back", 32'(want.write_back), 32'(got.write_back));
          check_field("divide_by_zero", 32'(want.div_zero), 32'(got.div_zero));
          check_field("zero_flag", 32'(want.zero), 32'(got.zero));
          check_field("negative_flag", 32'(want.negative), 32'(got.negative));
          check_field("odd_flag", 32'(want.odd), 32'(got.odd));
          check_field("borrow_flag", 32'(want.borrow), 32'(got.borrow));
          check_field("overflow_flag", 32'(want.overflow), 32'(got.overflow));
        end
      end
    end
    pending <= alu_results.size();
  end

endmodule

/* tb/sv/tb_remainder_compare_alu_with_flags.sv */
// Testbench top for the remainder and compare ALU: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_remainder_compare_alu_with_flags;
  import rcaf_pkg::*;

  // Number of random items sent, ignored codes included.
  localparam int RANDOM_ITEMS = 1750;
  // Cycles to wait after the last result. The longest item is a 32-bit remainder.
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [5:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [6:0]  m_tuser;
  int          errors;
  int          pending;

  // Receiver state: the stall style changes now and then, so that some stretches run
  // with the output always ready and others stall in short or long runs.
  int          sink_style = 0;
  int          sink_left  = 0;
  int          stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  remainder_compare_alu_with_flags u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // The checker sees both channels exactly as the block does and keeps its own flags.
  rcaf_alu_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // Presents one item and returns at the edge where it is taken. The valid stays high,
  // so a following call continues the burst without a bubble.
  task automatic push_item(input mode_t op, input wid_t wsel, input ext_t ext,
                           input logic [31:0] first, input logic [31:0] second);
    s_tvalid <= 1'b1;
    s_tdata  <= {second, first};
    s_tuser  <= {ext, wsel, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Operands lean toward the values where the arithmetic turns: zero, one, all ones,
  // the sign bits of each width, small magnitudes of either sign, and plain random.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 13))
      0:       v = 32'd0;
      1:       v = 32'd1;
      2:       v = 32'hFFFF_FFFF;
      3:       v = SIGN_8;
      4:       v = SIGN_16;
      5:       v = SIGN_32;
      6:       v = SIGN_8 - 32'd1;
      7:       v = SIGN_16 - 32'd1;
      8:       v = SIGN_32 - 32'd1;
      9:       v = $urandom_range(1, 40);
      10:      v = 32'd0 - $urandom_range(1, 40);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver stall pattern, driven at the rising edge like every other input.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_style <= $urandom_range(0, 2);
      sink_left  <= $urandom_range(20, 300);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_left > 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 12);
          end
        end
      end
    endcase
  end

  initial begin
    int    sent;
    int    burst;
    int    gap;
    int    pick;
    mode_t op;
    wid_t  wsel;
    ext_t  ext;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: width extremes, every operation and each special case.
    push_item(MODE_UREM, WID_32, EXT_NONE, 32'hFFFF_FFFF, 32'h0000_000A);
    // Upper bits beyond the width must be cut away from both operands.
    push_item(MODE_UREM, WID_8, EXT_NONE, 32'h1234_56FF, 32'hABCD_EF10);
    push_item(MODE_UREM, WID_16, EXT_NONE, 32'h0000_FFFF, 32'h0000_FFFF);
    // Zero divisor: trap raised, flags must stay as the last item left them.
    push_item(MODE_UREM, WID_32, EXT_NONE, 32'h1234_5678, 32'h0000_0000);
    // Most negative value modulo minus one, at every width.
    push_item(MODE_SREM, WID_8, EXT_NONE, 32'h0000_0080, 32'h0000_00FF);
    push_item(MODE_SREM, WID_16, EXT_NONE, 32'h0000_8000, 32'h0000_FFFF);
    push_item(MODE_SREM, WID_32, EXT_NONE, 32'h8000_0000, 32'hFFFF_FFFF);
    // Signed remainder takes the sign of the dividend; the last cuts its divisor to zero.
    push_item(MODE_SREM, WID_32, EXT_NONE, 32'hFFFF_FFF9, 32'h0000_0002);
    push_item(MODE_SREM, WID_8, EXT_NONE, 32'h0000_0007, 32'h0000_00FD);
    push_item(MODE_SREM, WID_16, EXT_NONE, 32'h0000_1234, 32'hFFFF_0000);
    // Compares: equal, borrow, and signed overflow in both directions.
    push_item(MODE_CMP, WID_32, EXT_NONE, 32'h0000_0005, 32'h0000_0005);
    push_item(MODE_CMP, WID_8, EXT_NONE, 32'h0000_0001, 32'h0000_0002);
    push_item(MODE_CMP, WID_8, EXT_NONE, 32'h0000_0080, 32'h0000_0001);
    push_item(MODE_CMP, WID_16, EXT_NONE, 32'h0000_7FFF, 32'h0000_FFFF);
    push_item(MODE_CMP, WID_32, EXT_NONE, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(MODE_CMP, WID_32, EXT_NONE, 32'hFFFF_FFFF, 32'h0000_0000);
    // Ignored codes: no write, no trap, flags untouched.
    push_item(MODE_NONE, WID_32, EXT_NONE, 32'h0000_0005, 32'h0000_0003);
    push_item(MODE_UREM, WID_NONE, EXT_NONE, 32'h0000_0005, 32'h0000_0003);
    // Sign extension of the second operand, including wider than the width.
    push_item(MODE_UREM, WID_32, EXT_8, 32'h0000_0064, 32'h0000_00F9);
    push_item(MODE_SREM, WID_32, EXT_16, 32'hFFFF_0000, 32'h0000_8003);
    push_item(MODE_CMP, WID_8, EXT_16, 32'h0000_008F, 32'h1234_80F0);
    // Extension that leaves a zero divisor.
    push_item(MODE_UREM, WID_16, EXT_8, 32'h0000_1234, 32'hFFFF_FF00);
    // The spare extension code passes the operand through.
    push_item(MODE_UREM, WID_32, EXT_SPARE, 32'hABCD_EF01, 32'h0000_1000);
    push_item(MODE_SREM, WID_16, EXT_SPARE, 32'h0000_8001, 32'h0000_7FFF);

    // Random part: bursts of random length, separated by random gaps or none at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick = $urandom_range(0, 19);
        op   = (pick < 6) ? MODE_UREM : (pick < 12) ? MODE_SREM :
               (pick < 19) ? MODE_CMP : MODE_NONE;
        pick = $urandom_range(0, 19);
        wsel = (pick < 6) ? WID_8 : (pick < 12) ? WID_16 : (pick < 19) ? WID_32 : WID_NONE;
        pick = $urandom_range(0, 5);
        ext  = (pick > 3) ? EXT_NONE : ext_t'(pick);
        push_item(op, wsel, ext, pick_operand(), pick_operand());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    // Let the last acceptance reach the checker, then wait for every expected result.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_remainder_compare_alu_with_flags: clean");
    end else begin
      $display("tb_remainder_compare_alu_with_flags: errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run of the whole sequence.
  initial begin
    #2_000_000;
    $display("tb_remainder_compare_alu_with_flags: errors");
    $finish;
  end

endmodule

/* remainder_compare_alu_with_flags.f */
rtl/rcaf_pkg.sv
rtl/rcaf_sub_unit.sv
rtl/remainder_compare_alu_with_flags.sv
tb/sv/rcaf_alu_checker.sv
tb/sv/tb_remainder_compare_alu_with_flags.sv
